@@ rtl/tpms_pkg.sv @@
package tpms_pkg;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int ATAN_COUNT       = 30;
   localparam int CSR_IDX_W        = 3;

   localparam logic [CSR_IDX_W-1:0] REG_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_C     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_D     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START = 3'd5;

   localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;

   function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
      logic signed [35:0] r;
      case (i)
         5'd0:  r = 36'sd843314856;
         5'd1:  r = 36'sd497837829;
         5'd2:  r = 36'sd263043836;
         5'd3:  r = 36'sd133525158;
         5'd4:  r = 36'sd67021686;
         5'd5:  r = 36'sd33543515;
         5'd6:  r = 36'sd16775850;
         5'd7:  r = 36'sd8388437;
         5'd8:  r = 36'sd4194282;
         5'd9:  r = 36'sd2097149;
         5'd10: r = 36'sd1048575;
         5'd11: r = 36'sd524287;
         5'd12: r = 36'sd262143;
         5'd13: r = 36'sd131071;
         5'd14: r = 36'sd65535;
         5'd15: r = 36'sd32767;
         5'd16: r = 36'sd16383;
         5'd17: r = 36'sd8191;
         5'd18: r = 36'sd4095;
         5'd19: r = 36'sd2047;
         5'd20: r = 36'sd1023;
         5'd21: r = 36'sd511;
         5'd22: r = 36'sd255;
         5'd23: r = 36'sd127;
         5'd24: r = 36'sd63;
         5'd25: r = 36'sd31;
         5'd26: r = 36'sd15;
         5'd27: r = 36'sd8;
         5'd28: r = 36'sd4;
         5'd29: r = 36'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } ctl_type;
endpackage

@@ rtl/tpms_sine.sv @@
module tpms_sine #(
   parameter int FRAC_BITS    = tpms_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = tpms_pkg::CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  angle,
   output tpms_pkg::ctl_type   status,
   output logic signed [31:0]  sine
);
   import tpms_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_QUOT, S_PROD, S_REM, S_CORR, S_WRAP, S_FOLD, S_ROT
   } state_type;

   localparam int STEPS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
   localparam int SH = 30 - FRAC_BITS;
   // floor(2^64 / 2pi), 2pi in Q30; the quotient estimate is exact or one short
   localparam logic [63:0] RECIP_WIDE = 64'hFFFF_FFFF_FFFF_FFFF / 64'(Q30_TWO_PI);
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
   localparam logic [55:0] TWO_PI_W = 56'(Q30_TWO_PI);

   state_type state_ff, state_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic done_ff, done_in;
   logic neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [63:0] p_ff, p_in;
   logic [55:0] qd_ff, qd_in;
   logic [23:0] quot;
   logic [55:0] zmag;
   logic signed [35:0] zc;
   logic signed [35:0] dx, dy;
   logic signed [35:0] ysh;

   assign quot = 24'(p_ff >> (64 - SH));
   assign zmag = 56'(mag_ff) << SH;
   assign zc   = (z_ff >= Q30_TWO_PI) ? z_ff - Q30_TWO_PI : z_ff;
   assign dx   = y_ff >>> i_ff;
   assign dy   = x_ff >>> i_ff;

   always_comb begin
      state_in = state_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      done_in = 1'b0; neg_in = neg_ff; mag_in = mag_ff; p_in = p_ff; qd_in = qd_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            neg_in = angle[31];
            mag_in = angle[31] ? 32'(-angle) : 32'(angle);
            state_in = S_QUOT;
         end
         S_QUOT: begin
            p_in = 64'(mag_ff) * 64'(RECIP);
            state_in = S_PROD;
         end
         S_PROD: begin
            qd_in = 56'(quot) * TWO_PI_W;
            state_in = S_REM;
         end
         S_REM: begin
            // remainder is below two turns here
            z_in = 36'(zmag - qd_ff);
            state_in = S_CORR;
         end
         S_CORR: begin
            // remainder takes the sign of the angle
            z_in = neg_ff ? -zc : zc;
            state_in = S_WRAP;
         end
         S_WRAP: begin
            if (z_ff >= Q30_PI) z_in = z_ff - Q30_TWO_PI;
            else if (z_ff < -Q30_PI) z_in = z_ff + Q30_TWO_PI;
            state_in = S_FOLD;
         end
         S_FOLD: begin
            if (z_ff > Q30_HALF_PI) z_in = Q30_PI - z_ff;
            else if (z_ff < -Q30_HALF_PI) z_in = -Q30_PI - z_ff;
            x_in = Q30_GAIN; y_in = '0; i_in = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - atan_q30(i_ff);
            end else begin
               x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + atan_q30(i_ff);
            end
            i_in = i_ff + 5'd1;
            if (32'(i_ff) == STEPS - 1) begin
               state_in = S_IDLE; done_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; done_ff <= 1'b0;
      end else begin
         state_ff <= state_in; done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      neg_ff <= neg_in; mag_ff <= mag_in; p_ff <= p_in; qd_ff <= qd_in;
   end

   assign ysh = y_ff >>> SH;
   assign sine = ysh[31:0];
   assign status.start = start;
   assign status.busy  = (state_ff != S_IDLE);
   assign status.done  = done_ff;
endmodule

@@ rtl/tpms_mac.sv @@
module tpms_mac #(
   parameter int FRAC_BITS = tpms_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic signed [31:0] op_p,
   input  logic signed [31:0] op_q,
   output logic signed [63:0] prod
);
   logic signed [63:0] p_ff;
   always_ff @(posedge clock) begin
      p_ff <= 64'(op_p) * 64'(op_q);
   end
   // arithmetic shift is floor
   assign prod = p_ff >>> FRAC_BITS;
endmodule

@@ rtl/thermal_plant_model_step.sv @@
// linear mode: two multiplies; nonlinear mode: square, angle reduction and folding,
// the rotations, four multiplies
// one word is processed at a time; a new word is taken while the last result waits,
// and a finished word holds in DONE until the result register is free
// reset clears coefficients, mode, temperature and history to zero
module thermal_plant_model_step #(
   parameter int FRAC_BITS    = tpms_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = tpms_pkg::CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [31:0]           req_heat_flow,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [31:0]           rsp_temperature,
   output logic                         rsp_saturated,
   input  logic                         csr_write_enable,
   input  logic [tpms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                  csr_write_data
);
   import tpms_pkg::*;

   typedef enum logic [2:0] {IDLE, SINE, MUL, ACC, SQ, DONE} state_type;

   state_type state_ff, state_in;
   logic mode_ff;
   logic signed [31:0] a_ff, b_ff, c_ff, d_ff, st_ff;
   logic signed [31:0] t_ff, t_in, tp_ff, tp_in, up_ff, up_in, u_ff, u_in;
   logic signed [31:0] sq_ff, sq_in, sn_ff, sn_in;
   logic signed [65:0] acc_ff, acc_in;
   logic [2:0] k_ff, k_in;
   logic sat_ff, sat_in, flag_ff, flag_in, vld_ff, vld_in;
   logic signed [31:0] res_ff, res_in;
   logic signed [31:0] op_p, op_q;
   logic signed [63:0] prod;
   ctl_type sst;
   logic sin_go;

   tpms_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (.clock, .op_p, .op_q, .prod);
   tpms_sine #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sine (
      .clock, .reset, .start(sin_go), .angle(up_ff), .status(sst), .sine(sn_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0; st_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_MODE:  mode_ff <= csr_write_data[0];
            REG_A:     a_ff <= csr_write_data;
            REG_B:     b_ff <= csr_write_data;
            REG_C:     c_ff <= csr_write_data;
            REG_D:     d_ff <= csr_write_data;
            REG_START: st_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // multiplier operand schedule: k0 a*T, k1 b*u or b*sq, k2 c*u, k3 d*sin, k4 tp*tp
   always_comb begin
      op_p = a_ff; op_q = t_ff;
      case (k_ff)
         3'd0: begin op_p = a_ff; op_q = t_ff; end
         3'd1: begin op_p = b_ff; op_q = mode_ff ? sq_ff : u_ff; end
         3'd2: begin op_p = c_ff; op_q = u_ff; end
         3'd3: begin op_p = d_ff; op_q = sn_ff; end
         default: begin op_p = tp_ff; op_q = tp_ff; end
      endcase
   end

   assign sin_go = (state_ff == SINE) && !sst.busy && !sst.done && k_ff == 3'd0;

   always_comb begin
      state_in = state_ff; t_in = t_ff; tp_in = tp_ff; up_in = up_ff; u_in = u_ff;
      sq_in = sq_ff; acc_in = acc_ff; k_in = k_ff; sat_in = sat_ff; flag_in = flag_ff;
      vld_in = vld_ff; res_in = res_ff;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      unique case (state_ff)
         IDLE: if (req_valid) begin
            u_in = req_heat_flow; flag_in = 1'b0; acc_in = '0;
            if (req_restart) begin
               t_in = st_ff; tp_in = '0; up_in = '0;
            end
            if (mode_ff) begin
               state_in = SQ; k_in = 3'd4;
            end else begin
               state_in = MUL; k_in = 3'd0;
            end
         end
         SQ: state_in = ACC;
         SINE: begin
            k_in = 3'd1;
            if (sst.done) begin
               state_in = MUL; k_in = 3'd0;
            end
         end
         MUL: state_in = ACC;
         ACC: begin
            if (k_ff == 3'd4) begin
               if (prod > 64'sd2147483647) begin sq_in = 32'sh7fffffff; flag_in = 1'b1; end
               else if (prod < -64'sd2147483648) begin
                  sq_in = 32'sh80000000; flag_in = 1'b1;
               end else sq_in = prod[31:0];
               state_in = SINE; k_in = 3'd0;
            end else begin
               if (mode_ff && k_ff == 3'd1) acc_in = acc_ff - 66'(prod);
               else acc_in = acc_ff + 66'(prod);
               if (k_ff == 3'd3 || (!mode_ff && k_ff == 3'd1)) state_in = DONE;
               else begin
                  k_in = k_ff + 3'd1; state_in = MUL;
               end
            end
         end
         DONE: begin
            // hold until the result register is free
            if (!vld_ff || rsp_ready) begin
               sat_in = flag_ff;
               if (acc_ff > 66'sd2147483647) begin
                  res_in = 32'sh7fffffff; sat_in = 1'b1;
               end else if (acc_ff < -66'sd2147483648) begin
                  res_in = 32'sh80000000; sat_in = 1'b1;
               end else res_in = acc_ff[31:0];
               tp_in = t_ff; up_in = u_ff;
               t_in = res_in;
               vld_in = 1'b1; state_in = IDLE; k_in = 3'd0;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE; vld_ff <= 1'b0;
         t_ff <= '0; tp_ff <= '0; up_ff <= '0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
         t_ff <= t_in; tp_ff <= tp_in; up_ff <= up_in;
      end
      u_ff <= u_in; sq_ff <= sq_in; acc_ff <= acc_in; k_ff <= k_in;
      sat_ff <= sat_in; flag_ff <= flag_in; res_ff <= res_in;
      if (sst.done) sn_ff <= sn_in;
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_temperature = res_ff;
   assign rsp_saturated = sat_ff;
   logic unused;
   assign unused = sst.start;
endmodule
